@@ hdl/lidct_pkg.sv @@
// lidct_pkg: types, constants and lifting microcode for the 8x8 lifting idct
// used by the controller, the datapath and the top level; depends on nothing
`timescale 1ns / 1ps

package lidct_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ADDR_W    = 6;
    localparam int STEP_W    = 6;
    localparam int LAST_UOP  = 49;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_RD,
        ST_MUL,
        ST_ADD,
        ST_WR,
        ST_ORD,
        ST_OLD,
        ST_OWAIT
    } state_t;

    typedef enum logic [1:0] {
        UK_NEG,
        UK_ADD,
        UK_SUB
    } uop_kind_t;

    typedef enum logic [2:0] {
        K_TAN1,
        K_TAN3,
        K_TAN4,
        K_TAN2,
        K_SIN1,
        K_SIN3,
        K_SIN2,
        K_SIN4
    } kconst_t;

    typedef enum logic [2:0] {
        RF_NONE,
        RF_LOAD,
        RF_NEG,
        RF_ADD,
        RF_SUB
    } rf_op_t;

    typedef struct packed {
        uop_kind_t   kind;
        logic [2:0]  dst;
        logic [2:0]  src;
        kconst_t     k;
    } uop_t;

    typedef struct packed {
        logic              ram_we;
        logic              ram_src_coef;
        logic [ADDR_W-1:0] ram_waddr;
        logic [ADDR_W-1:0] ram_raddr;
        logic              first;
        rf_op_t            rf_op;
        logic [2:0]        rf_ridx;
        logic [2:0]        rf_widx;
        kconst_t           k;
        logic              mul_en;
        logic              out_load;
        logic              out_zero;
        logic              out_last;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
        logic out_ready;
    } sts_t;

    function automatic logic [FRAC_BITS-1:0] kval(kconst_t k);
        logic [FRAC_BITS-1:0] v;
        case (k)
            K_TAN1:  v = 12'd403;
            K_TAN3:  v = 12'd1243;
            K_TAN4:  v = 12'd1697;
            K_TAN2:  v = 12'd815;
            K_SIN1:  v = 12'd799;
            K_SIN3:  v = 12'd2276;
            K_SIN2:  v = 12'd1567;
            K_SIN4:  v = 12'd2896;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic uop_t mk(uop_kind_t kd, logic [2:0] d, logic [2:0] s, kconst_t k);
        uop_t u;
        u.kind = kd;
        u.dst  = d;
        u.src  = s;
        u.k    = k;
        return u;
    endfunction

    // one lifting step per entry: dst = dst -/+ round(src * k), or dst = -dst
    function automatic uop_t uop_at(logic [STEP_W-1:0] s);
        uop_t u;
        case (s)
            6'd0:    u = mk(UK_NEG, 3'd3, 3'd3, K_TAN4);
            6'd1:    u = mk(UK_NEG, 3'd4, 3'd4, K_TAN4);
            6'd2:    u = mk(UK_NEG, 3'd6, 3'd6, K_TAN4);
            6'd3:    u = mk(UK_SUB, 3'd5, 3'd3, K_TAN4);
            6'd4:    u = mk(UK_ADD, 3'd3, 3'd5, K_SIN4);
            6'd5:    u = mk(UK_SUB, 3'd5, 3'd3, K_TAN4);
            6'd6:    u = mk(UK_SUB, 3'd0, 3'd4, K_TAN4);
            6'd7:    u = mk(UK_SUB, 3'd2, 3'd6, K_TAN2);
            6'd8:    u = mk(UK_ADD, 3'd4, 3'd0, K_SIN4);
            6'd9:    u = mk(UK_ADD, 3'd6, 3'd2, K_SIN2);
            6'd10:   u = mk(UK_SUB, 3'd0, 3'd4, K_TAN4);
            6'd11:   u = mk(UK_SUB, 3'd2, 3'd6, K_TAN2);
            6'd12:   u = mk(UK_NEG, 3'd5, 3'd5, K_TAN4);
            6'd13:   u = mk(UK_SUB, 3'd1, 3'd5, K_TAN4);
            6'd14:   u = mk(UK_ADD, 3'd5, 3'd1, K_SIN4);
            6'd15:   u = mk(UK_SUB, 3'd1, 3'd5, K_TAN4);
            6'd16:   u = mk(UK_NEG, 3'd7, 3'd7, K_TAN4);
            6'd17:   u = mk(UK_SUB, 3'd3, 3'd7, K_TAN4);
            6'd18:   u = mk(UK_ADD, 3'd7, 3'd3, K_SIN4);
            6'd19:   u = mk(UK_SUB, 3'd3, 3'd7, K_TAN4);
            6'd20:   u = mk(UK_SUB, 3'd1, 3'd7, K_TAN1);
            6'd21:   u = mk(UK_SUB, 3'd5, 3'd3, K_TAN3);
            6'd22:   u = mk(UK_ADD, 3'd7, 3'd1, K_SIN1);
            6'd23:   u = mk(UK_ADD, 3'd3, 3'd5, K_SIN3);
            6'd24:   u = mk(UK_SUB, 3'd1, 3'd7, K_TAN1);
            6'd25:   u = mk(UK_SUB, 3'd5, 3'd3, K_TAN3);
            6'd26:   u = mk(UK_NEG, 3'd2, 3'd2, K_TAN4);
            6'd27:   u = mk(UK_SUB, 3'd0, 3'd2, K_TAN4);
            6'd28:   u = mk(UK_ADD, 3'd2, 3'd0, K_SIN4);
            6'd29:   u = mk(UK_SUB, 3'd0, 3'd2, K_TAN4);
            6'd30:   u = mk(UK_NEG, 3'd6, 3'd6, K_TAN4);
            6'd31:   u = mk(UK_SUB, 3'd4, 3'd6, K_TAN4);
            6'd32:   u = mk(UK_ADD, 3'd6, 3'd4, K_SIN4);
            6'd33:   u = mk(UK_SUB, 3'd4, 3'd6, K_TAN4);
            6'd34:   u = mk(UK_NEG, 3'd1, 3'd1, K_TAN4);
            6'd35:   u = mk(UK_SUB, 3'd0, 3'd1, K_TAN4);
            6'd36:   u = mk(UK_ADD, 3'd1, 3'd0, K_SIN4);
            6'd37:   u = mk(UK_SUB, 3'd0, 3'd1, K_TAN4);
            6'd38:   u = mk(UK_NEG, 3'd5, 3'd5, K_TAN4);
            6'd39:   u = mk(UK_SUB, 3'd4, 3'd5, K_TAN4);
            6'd40:   u = mk(UK_ADD, 3'd5, 3'd4, K_SIN4);
            6'd41:   u = mk(UK_SUB, 3'd4, 3'd5, K_TAN4);
            6'd42:   u = mk(UK_NEG, 3'd3, 3'd3, K_TAN4);
            6'd43:   u = mk(UK_SUB, 3'd6, 3'd3, K_TAN4);
            6'd44:   u = mk(UK_ADD, 3'd3, 3'd6, K_SIN4);
            6'd45:   u = mk(UK_SUB, 3'd6, 3'd3, K_TAN4);
            6'd46:   u = mk(UK_NEG, 3'd7, 3'd7, K_TAN4);
            6'd47:   u = mk(UK_SUB, 3'd2, 3'd7, K_TAN4);
            6'd48:   u = mk(UK_ADD, 3'd7, 3'd2, K_SIN4);
            6'd49:   u = mk(UK_SUB, 3'd2, 3'd7, K_TAN4);
            default: u = mk(UK_NEG, 3'd0, 3'd0, K_TAN4);
        endcase
        return u;
    endfunction

    // working register that holds output position o after the last step
    function automatic logic [2:0] wb_reg(logic [2:0] o);
        logic [2:0] r;
        case (o)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd6;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd7;
            3'd5:    r = 3'd3;
            3'd6:    r = 3'd5;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/lidct_if.sv @@
// lidct_coef_if and lidct_sample_if: valid/ready channels of the 8x8 lifting idct
// depends on nothing
`timescale 1ns / 1ps

interface lidct_coef_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] coefficient;
    logic        [15:0] quant_step;
    logic signed [24:0] dc_offset;

    modport source (output valid, op, coefficient, quant_step, dc_offset, input ready);
    modport sink   (input valid, op, coefficient, quant_step, dc_offset, output ready);
endinterface

interface lidct_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               last;

    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

@@ hdl/lidct_ram.sv @@
// lidct_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module lidct_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lidct_dp.sv @@
// lidct_dp: dequantiser, block ram, working registers, shared lifting unit, output register
// depends on lidct_pkg and lidct_ram
`timescale 1ns / 1ps

module lidct_dp #(
    parameter int INNER_WIDTH = 48,
    parameter int PRESHIFT    = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lidct_pkg::cmd_t     cmd,
    output lidct_pkg::sts_t     sts,
    input  logic signed [15:0]  coefficient,
    input  logic        [15:0]  quant_step,
    input  logic signed [24:0]  dc_offset,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  sample,
    output logic                last
);

    logic signed [INNER_WIDTH-1:0] rf_reg [8];
    logic signed [INNER_WIDTH-1:0] prod_reg;
    logic signed [INNER_WIDTH-1:0] prod_next;
    logic signed [INNER_WIDTH-1:0] rd;
    logic signed [INNER_WIDTH-1:0] rnd;
    logic signed [INNER_WIDTH-1:0] mr_val;
    logic signed [32:0]            dq_prod;
    logic signed [27:0]            dc_sh;
    logic signed [INNER_WIDTH-1:0] dq;
    logic        [INNER_WIDTH-1:0] ram_wdata;
    logic        [INNER_WIDTH-1:0] ram_rdata;
    logic signed [31:0]            sample_reg;
    logic                          last_reg;
    logic                          valid_reg;
    logic                          valid_next;
    logic signed [lidct_pkg::FRAC_BITS:0] kop;

    // dequantise, level shift only on the first coefficient of a block
    assign dq_prod = coefficient * $signed({1'b0, quant_step});
    assign dc_sh   = {dc_offset, 3'b000};
    assign dq      = INNER_WIDTH'(dq_prod) + (cmd.first ? INNER_WIDTH'(dc_sh) : '0);

    assign rd        = rf_reg[cmd.rf_ridx];
    assign ram_wdata = cmd.ram_src_coef ? dq : rd;

    lidct_ram #(
        .WIDTH (INNER_WIDTH),
        .DEPTH (64)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (cmd.ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmd.ram_raddr),
        .rdata (ram_rdata)
    );

    // shear: product wraps, then round half up and arithmetic shift
    assign kop       = $signed({1'b0, lidct_pkg::kval(cmd.k)});
    assign prod_next = rd * kop;
    assign rnd       = prod_reg + INNER_WIDTH'(1 << (lidct_pkg::FRAC_BITS - 1));
    assign mr_val    = rnd >>> lidct_pkg::FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        case (cmd.rf_op)
            lidct_pkg::RF_LOAD: rf_reg[cmd.rf_widx] <= ram_rdata;
            lidct_pkg::RF_NEG:  rf_reg[cmd.rf_widx] <= -rd;
            lidct_pkg::RF_ADD:  rf_reg[cmd.rf_widx] <= rd + mr_val;
            lidct_pkg::RF_SUB:  rf_reg[cmd.rf_widx] <= rd - mr_val;
            default:            ;
        endcase
        if (cmd.out_load)
        begin
            sample_reg <= cmd.out_zero ? '0 : $signed(ram_rdata[31:0] << PRESHIFT);
            last_reg   <= cmd.out_last;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid     = valid_reg;
    assign sample        = sample_reg;
    assign last          = last_reg;
    assign sts.out_valid = valid_reg;
    assign sts.out_ready = out_ready;

endmodule

@@ hdl/lidct_ctrl.sv @@
// lidct_ctrl: sequencer for block fill, row and column lifting passes and sample readout
// depends on lidct_pkg
`timescale 1ns / 1ps

module lidct_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_op,
    output logic            in_ready,
    output lidct_pkg::cmd_t cmd,
    input  lidct_pkg::sts_t sts
);

    lidct_pkg::state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  ocnt_reg, ocnt_next;
    logic [2:0]  line_reg, line_next;
    logic        pass_reg, pass_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [lidct_pkg::STEP_W-1:0] step_reg, step_next;
    logic        zero_reg, zero_next;
    lidct_pkg::uop_t u;

    assign u = lidct_pkg::uop_at(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lidct_pkg::ST_FILL;
            fill_reg  <= '0;
            ocnt_reg  <= '0;
            line_reg  <= '0;
            pass_reg  <= 1'b0;
            cnt_reg   <= '0;
            step_reg  <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ocnt_reg  <= ocnt_next;
            line_reg  <= line_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            zero_reg  <= zero_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ocnt_next  = ocnt_reg;
        line_next  = line_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        zero_next  = zero_reg;
        in_ready   = 1'b0;
        cmd        = '0;

        case (state_reg)
            lidct_pkg::ST_FILL:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op)
                    begin
                        // empty block drops any partial fill
                        fill_next  = '0;
                        ocnt_next  = '0;
                        zero_next  = 1'b1;
                        state_next = lidct_pkg::ST_ORD;
                    end
                    else
                    begin
                        cmd.ram_we       = 1'b1;
                        cmd.ram_src_coef = 1'b1;
                        cmd.ram_waddr    = fill_reg;
                        cmd.first        = (fill_reg == '0);
                        fill_next        = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            pass_next  = 1'b0;
                            line_next  = '0;
                            cnt_next   = '0;
                            zero_next  = 1'b0;
                            state_next = lidct_pkg::ST_RD;
                        end
                    end
                end
            end

            lidct_pkg::ST_RD:
            begin
                // read data comes from the ram's registered output, so each load trails its address
                cmd.ram_raddr = pass_reg ? {cnt_reg[2:0], line_reg} : {line_reg, cnt_reg[2:0]};
                if (cnt_reg != 4'd0)
                begin
                    cmd.rf_op   = lidct_pkg::RF_LOAD;
                    cmd.rf_widx = 3'(cnt_reg - 4'd1);
                end
                if (cnt_reg == 4'd8)
                begin
                    step_next  = '0;
                    state_next = lidct_pkg::ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end

            lidct_pkg::ST_MUL:
            begin
                if (u.kind == lidct_pkg::UK_NEG)
                begin
                    cmd.rf_op   = lidct_pkg::RF_NEG;
                    cmd.rf_ridx = u.dst;
                    cmd.rf_widx = u.dst;
                    if (step_reg == lidct_pkg::STEP_W'(lidct_pkg::LAST_UOP))
                    begin
                        cnt_next   = '0;
                        state_next = lidct_pkg::ST_WR;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.rf_ridx = u.src;
                    cmd.k       = u.k;
                    cmd.mul_en  = 1'b1;
                    state_next  = lidct_pkg::ST_ADD;
                end
            end

            lidct_pkg::ST_ADD:
            begin
                cmd.rf_op   = (u.kind == lidct_pkg::UK_ADD) ? lidct_pkg::RF_ADD
                                                            : lidct_pkg::RF_SUB;
                cmd.rf_ridx = u.dst;
                cmd.rf_widx = u.dst;
                if (step_reg == lidct_pkg::STEP_W'(lidct_pkg::LAST_UOP))
                begin
                    cnt_next   = '0;
                    state_next = lidct_pkg::ST_WR;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = lidct_pkg::ST_MUL;
                end
            end

            lidct_pkg::ST_WR:
            begin
                cmd.rf_ridx   = lidct_pkg::wb_reg(cnt_reg[2:0]);
                cmd.ram_we    = 1'b1;
                cmd.ram_waddr = pass_reg ? {cnt_reg[2:0], line_reg} : {line_reg, cnt_reg[2:0]};
                if (cnt_reg == 4'd7)
                begin
                    cnt_next = '0;
                    if (line_reg == 3'd7)
                    begin
                        line_next = '0;
                        if (!pass_reg)
                        begin
                            pass_next  = 1'b1;
                            state_next = lidct_pkg::ST_RD;
                        end
                        else
                        begin
                            ocnt_next  = '0;
                            state_next = lidct_pkg::ST_ORD;
                        end
                    end
                    else
                    begin
                        line_next  = line_reg + 3'd1;
                        state_next = lidct_pkg::ST_RD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end

            lidct_pkg::ST_ORD:
            begin
                cmd.ram_raddr = ocnt_reg;
                state_next    = lidct_pkg::ST_OLD;
            end

            lidct_pkg::ST_OLD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_zero = zero_reg;
                cmd.out_last = (ocnt_reg == 6'd63);
                state_next   = lidct_pkg::ST_OWAIT;
            end

            lidct_pkg::ST_OWAIT:
            begin
                if (sts.out_valid && sts.out_ready)
                begin
                    if (ocnt_reg == 6'd63)
                    begin
                        state_next = lidct_pkg::ST_FILL;
                    end
                    else
                    begin
                        ocnt_next  = ocnt_reg + 6'd1;
                        state_next = lidct_pkg::ST_ORD;
                    end
                end
            end

            default:
            begin
                state_next = lidct_pkg::ST_FILL;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_out_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lidct_pkg::ST_FILL |-> !sts.out_valid)
        else $error("sample pending while filling");
    a_add_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lidct_pkg::ST_ADD |-> $past(state_reg) == lidct_pkg::ST_MUL)
        else $error("lifting add without product");
    a_beat_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.out_valid && sts.out_ready |-> state_reg == lidct_pkg::ST_OWAIT)
        else $error("output beat outside readout");
    a_rd_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lidct_pkg::ST_RD |-> cnt_reg <= 4'd8)
        else $error("line read count overrun");
`endif

endmodule

@@ hdl/lifting_idct_8x8_dequant.sv @@
// a block is 64 coefficient beats (one per cycle), then 16 lines of lifting, each
// a line read, 11 negations and 39 shears on the one shared multiplier, a line write,
// then 64 samples, each read from the ram and held until taken; an empty block gives 64 zeros
// one block in flight at a time; async active-low reset returns to fill with no sample
// pending, block ram contents are not cleared
// top level: joins lidct_ctrl and lidct_dp; depends on lidct_pkg and lidct_if
`timescale 1ns / 1ps

module lifting_idct_8x8_dequant #(
    parameter int PRESHIFT    = 0,
    parameter int INNER_WIDTH = 48
) (
    input  logic           clk,
    input  logic           rst_n,
    lidct_coef_if.sink     coef_ch,
    lidct_sample_if.source sample_ch
);

    lidct_pkg::cmd_t cmd;
    lidct_pkg::sts_t sts;

    lidct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (coef_ch.valid),
        .in_op    (coef_ch.op),
        .in_ready (coef_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lidct_dp #(
        .INNER_WIDTH (INNER_WIDTH),
        .PRESHIFT    (PRESHIFT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .coefficient (coef_ch.coefficient),
        .quant_step  (coef_ch.quant_step),
        .dc_offset   (coef_ch.dc_offset),
        .out_valid   (sample_ch.valid),
        .out_ready   (sample_ch.ready),
        .sample      (sample_ch.sample),
        .last        (sample_ch.last)
    );

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for the dequantizing 8x8 lifting idct
// depends on lidct_pkg, lidct_if and lifting_idct_8x8_dequant
`timescale 1ns / 1ps

module tb_top;

    localparam int PRESHIFT    = 0;
    localparam int INNER_WIDTH = 48;
    localparam int RAND_ITEMS  = 30;
    localparam int HOLD_CYCLES = 400;

    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_EMPTY = 1'b1;

    localparam logic [63:0] C_TAN1 = 64'd403;
    localparam logic [63:0] C_TAN3 = 64'd1243;
    localparam logic [63:0] C_TAN4 = 64'd1697;
    localparam logic [63:0] C_TAN2 = 64'd815;
    localparam logic [63:0] C_SIN1 = 64'd799;
    localparam logic [63:0] C_SIN3 = 64'd2276;
    localparam logic [63:0] C_SIN2 = 64'd1567;
    localparam logic [63:0] C_SIN4 = 64'd2896;

    typedef struct {
        logic               op;
        logic signed [15:0] coefficient;
        logic        [15:0] quant_step;
        logic signed [24:0] dc_offset;
    } coef_beat_t;

    typedef struct {
        logic [31:0] sample;
        logic        last;
    } sample_beat_t;

    logic clk;
    logic rst_n;

    lidct_coef_if   coef_ch ();
    lidct_sample_if sample_ch ();

    lifting_idct_8x8_dequant #(
        .PRESHIFT    (PRESHIFT),
        .INNER_WIDTH (INNER_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef_ch   (coef_ch.sink),
        .sample_ch (sample_ch.source)
    );

    // predictor state
    logic [63:0]  coef_store [64];
    int           fill_level;
    sample_beat_t samples_due [$];
    coef_beat_t   beats_to_send [$];

    int  error_count;
    int  samples_seen;
    int  blocks_seen;
    bit  stim_done;
    bit  hold_req;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] wrap_inner(logic [63:0] v);
        logic [63:0] m;
        m = (INNER_WIDTH >= 64) ? '1 : ((64'd1 << INNER_WIDTH) - 64'd1);
        v &= m;
        if (v[INNER_WIDTH-1])
            v |= ~m;
        return v;
    endfunction

    function automatic logic [63:0] shear(logic [63:0] x, logic [63:0] k);
        logic [63:0] t;
        t = wrap_inner(x * k);
        t = wrap_inner(t + 64'd2048);
        return $unsigned($signed(t) >>> 12);
    endfunction

    function automatic logic [63:0] isub(logic [63:0] a, logic [63:0] b);
        return wrap_inner(a - b);
    endfunction

    function automatic logic [63:0] iadd(logic [63:0] a, logic [63:0] b);
        return wrap_inner(a + b);
    endfunction

    function automatic logic [63:0] ineg(logic [63:0] a);
        return wrap_inner(64'd0 - a);
    endfunction

    task automatic rotate_pair(inout logic [63:0] a, inout logic [63:0] b);
        logic [63:0] p;
        logic [63:0] q;
        p = a;
        q = ineg(b);
        p = isub(p, shear(q, C_TAN4));
        q = iadd(q, shear(p, C_SIN4));
        p = isub(p, shear(q, C_TAN4));
        a = p;
        b = q;
    endtask

    task automatic lifting_idct8(inout logic [63:0] v [8]);
        logic [63:0] z20, zc0, z21, z1, z10, x45, z11, zc2;
        logic [63:0] z0, zc3, zc1, z00, z01, zb0, zb1, zb2, zb3;
        logic [63:0] x0, x1, x2, x3, x4, x5, x6, x7;
        z20 = v[0]; zc0 = v[1]; z21 = v[2]; z1 = ineg(v[3]);
        z10 = ineg(v[4]); x45 = v[5]; z11 = ineg(v[6]); zc2 = v[7];
        z0  = isub(x45, shear(z1, C_TAN4));
        zc3 = iadd(z1, shear(z0, C_SIN4));
        zc1 = isub(z0, shear(zc3, C_TAN4));
        z00 = isub(z20, shear(z10, C_TAN4));
        z01 = isub(z21, shear(z11, C_TAN2));
        zb1 = iadd(z10, shear(z00, C_SIN4));
        zb3 = iadd(z11, shear(z01, C_SIN2));
        zb0 = isub(z00, shear(zb1, C_TAN4));
        zb2 = isub(z01, shear(zb3, C_TAN2));
        zc1 = ineg(zc1);
        zc0 = isub(zc0, shear(zc1, C_TAN4));
        z21 = iadd(zc1, shear(zc0, C_SIN4));
        z20 = isub(zc0, shear(z21, C_TAN4));
        zc2 = ineg(zc2);
        zc3 = isub(zc3, shear(zc2, C_TAN4));
        z10 = iadd(zc2, shear(zc3, C_SIN4));
        z11 = isub(zc3, shear(z10, C_TAN4));
        z00 = isub(z20, shear(z10, C_TAN1));
        z01 = isub(z21, shear(z11, C_TAN3));
        x7  = iadd(z10, shear(z00, C_SIN1));
        x6  = iadd(z11, shear(z01, C_SIN3));
        x4  = isub(z00, shear(x7, C_TAN1));
        x5  = isub(z01, shear(x6, C_TAN3));
        zb2 = ineg(zb2);
        zb0 = isub(zb0, shear(zb2, C_TAN4));
        x3  = iadd(zb2, shear(zb0, C_SIN4));
        x0  = isub(zb0, shear(x3, C_TAN4));
        zb3 = ineg(zb3);
        zb1 = isub(zb1, shear(zb3, C_TAN4));
        x2  = iadd(zb3, shear(zb1, C_SIN4));
        x1  = isub(zb1, shear(x2, C_TAN4));
        rotate_pair(x0, x4);
        rotate_pair(x1, x5);
        rotate_pair(x2, x6);
        rotate_pair(x3, x7);
        v[0] = x0; v[7] = x4;
        v[1] = x1; v[6] = x5;
        v[2] = x2; v[5] = x6;
        v[3] = x3; v[4] = x7;
    endtask

    // dequantise; on the 64th beat transform and queue; empty beats queue 64 zeros
    task automatic predict_beat(coef_beat_t b);
        logic [63:0] blk [64];
        logic [63:0] line [8];
        logic [63:0] v;
        logic [63:0] shifted;
        sample_beat_t s;
        if (b.op == OP_EMPTY) begin
            fill_level = 0;
            for (int i = 0; i < 64; i++) begin
                s.sample = '0;
                s.last = (i == 63);
                samples_due.push_back(s);
            end
            return;
        end
        v = wrap_inner(64'($signed(b.coefficient)) * 64'(b.quant_step));
        if (fill_level == 0)
            v = iadd(v, wrap_inner(64'($signed(b.dc_offset)) << 3));
        coef_store[fill_level] = v;
        fill_level++;
        if (fill_level < 64)
            return;
        fill_level = 0;
        blk = coef_store;
        for (int r = 0; r < 8; r++) begin
            for (int i = 0; i < 8; i++)
                line[i] = blk[r*8 + i];
            lifting_idct8(line);
            for (int i = 0; i < 8; i++)
                blk[r*8 + i] = line[i];
        end
        for (int c = 0; c < 8; c++) begin
            for (int i = 0; i < 8; i++)
                line[i] = blk[i*8 + c];
            lifting_idct8(line);
            for (int i = 0; i < 8; i++)
                blk[i*8 + c] = line[i];
        end
        for (int i = 0; i < 64; i++) begin
            shifted = blk[i] << PRESHIFT;
            s.sample = shifted[31:0];
            s.last = (i == 63);
            samples_due.push_back(s);
        end
    endtask

    function automatic coef_beat_t mk_beat(logic op, logic signed [15:0] c,
                                           logic [15:0] q, logic signed [24:0] d);
        coef_beat_t b;
        b.op = op;
        b.coefficient = c;
        b.quant_step = q;
        b.dc_offset = d;
        return b;
    endfunction

    function automatic coef_beat_t rand_coef(bit wide);
        coef_beat_t b;
        b.op = OP_COEF;
        b.coefficient = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 64)) - 32);
        b.quant_step = wide ? 16'($urandom) : 16'($urandom_range(0, 40));
        b.dc_offset = 25'($urandom);
        return b;
    endfunction

    // stimulus list: directed beats first, then random blocks and cut-short fills
    initial begin
        int pick;
        int n;
        // empty block straight after reset, then one mid-fill
        beats_to_send.push_back(mk_beat(OP_EMPTY, 16'sh7fff, 16'hffff, 25'h0ffffff));
        for (int i = 0; i < 5; i++)
            beats_to_send.push_back(mk_beat(OP_COEF, 16'sh8000, 16'hffff, 25'h1000000));
        beats_to_send.push_back(mk_beat(OP_EMPTY, 16'sh8000, 16'h0000, 25'h1000000));
        // extremes: max and min coefficient, max and zero step, min dc
        for (int i = 0; i < 64; i++)
            beats_to_send.push_back(mk_beat(OP_COEF, (i % 2) ? 16'sh8000 : 16'sh7fff,
                                            (i % 3) ? 16'hffff : 16'h0000,
                                            (i == 0) ? 25'h1000000 : 25'h0ffffff));
        n = 0;
        while (n < RAND_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                beats_to_send.push_back(rand_coef(1));
                beats_to_send.push_back(mk_beat(OP_EMPTY, 16'($urandom), 16'($urandom),
                                                25'($urandom)));
                n += 2;
            end else begin
                for (int i = 0; i < 64; i++)
                    beats_to_send.push_back(rand_coef(pick > 5));
                n += 64;
            end
        end
    end

    // sender
    initial begin
        coef_beat_t b;
        int gap;
        coef_ch.valid = 1'b0;
        coef_ch.op = OP_COEF;
        coef_ch.coefficient = '0;
        coef_ch.quant_step = '0;
        coef_ch.dc_offset = '0;
        rst_n = 1'b0;
        fill_level = 0;
        error_count = 0;
        stim_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        #1;
        foreach (beats_to_send[k]) begin
            b = beats_to_send[k];
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (k == 0)
                @(posedge clk);
            if (gap > 0) begin
                coef_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            coef_ch.valid <= 1'b1;
            coef_ch.op <= b.op;
            coef_ch.coefficient <= b.coefficient;
            coef_ch.quant_step <= b.quant_step;
            coef_ch.dc_offset <= b.dc_offset;
            do
                @(posedge clk);
            while (!(coef_ch.valid && coef_ch.ready));
            predict_beat(b);
        end
        coef_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // long hold-off on the sample side while the sender keeps offering coefficients
    initial begin
        hold_req = 1'b0;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
    end

    // receiver and checker
    initial begin
        sample_beat_t e;
        int stall;
        sample_ch.ready = 1'b0;
        samples_seen = 0;
        blocks_seen = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (sample_ch.valid && sample_ch.ready) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: sample with none due: sample %h last %b", $time,
                             sample_ch.sample, sample_ch.last);
                    error_count++;
                end else begin
                    e = samples_due.pop_front();
                    if (sample_ch.sample !== e.sample) begin
                        $display("%0t: sample expected %h actual %h", $time, e.sample,
                                 sample_ch.sample);
                        error_count++;
                    end
                    if (sample_ch.last !== e.last) begin
                        $display("%0t: last expected %b actual %b", $time, e.last,
                                 sample_ch.last);
                        error_count++;
                    end
                end
                samples_seen++;
                if (sample_ch.last)
                    blocks_seen++;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            if (hold_req || stall > 0) begin
                sample_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_req) @(posedge clk);
            end
            sample_ch.ready <= 1'b1;
        end
    end

    initial begin
        wait (stim_done);
        wait (samples_due.size() == 0);
        repeat (300) @(posedge clk);
        $display("covered %0d coefficient beats, %0d blocks and %0d samples checked",
                 beats_to_send.size(), blocks_seen, samples_seen);
        if (error_count == 0 && samples_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
